// ===== sv/psp_pkg.sv =====
`default_nettype none

package psp_pkg;

  localparam int unsigned PduBufferBytes = 64;

  // Window of a signal: up to five bytes around the lsb byte
  localparam int unsigned WinBytes = 5;
  localparam int unsigned WinBits  = 8 * WinBytes;

  localparam int unsigned SigWidth = 32;
  localparam logic [5:0]  SizeMax  = 6'd32;

  typedef enum logic [1:0] {
    CMD_WR_BYTE = 2'd0,
    CMD_RD_BYTE = 2'd1,
    CMD_INSERT  = 2'd2,
    CMD_EXTRACT = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_WRITE = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  function automatic logic [5:0] clamp_size(input logic [5:0] size);
    logic [5:0] res;
    res = size;
    if (size == 6'd0) begin
      res = 6'd1;
    end else if (size > SizeMax) begin
      res = SizeMax;
    end
    return res;
  endfunction

  // Bytes spanned by a signal; size already clamped
  function automatic logic [2:0] span_bytes(input logic [2:0] pos_lo, input logic [5:0] size,
                                            input logic be);
    logic [3:0] first;
    logic [5:0] rest;
    logic [2:0] n;
    first = be ? ({1'b0, pos_lo} + 4'd1) : (4'd8 - {1'b0, pos_lo});
    rest  = size - {2'b00, first} + 6'd7;
    n     = 3'd1;
    if ({2'b00, first} <= size) begin
      n = 3'd1 + rest[5:3];
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pdu_signal_pack_unpack.sv =====
`default_nettype none

// Signal pack/unpack engine over a byte buffer of BUFFER_BYTES bytes held in one
// single-port-per-direction synchronous RAM. Commands (tuser): write byte, read byte,
// insert signal, extract signal. Signals are 1..32 bits in Intel or Motorola numbering
// and live in a five-byte window around their lsb byte; bytes outside the buffer read as
// zero and are never written. One command is worked at a time and the RAM moves one byte
// per cycle: a byte write writes one byte, a byte read reads one, extract reads five and
// insert reads five, then writes five back. The result sits in an output register, so a
// new command is taken while the previous result waits. After reset the RAM is zeroed by
// a clearing pass during which no command is taken.
module pdu_signal_pack_unpack
  import psp_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = PduBufferBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [5:0] byte_addr, [13:6] byte_data, [22:14] bit_pos, [28:23] bit_size,
  // [29] big_endian, [30] is_signed, [62:31] signal_in
  input  wire logic [63:0] s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] read_byte, [39:8] signal_out, [42:40] touched_bytes
  output logic [47:0]      m_axis_tdata_o
);

  localparam int unsigned ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CMP_W  = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;

  // input unpacking
  logic [5:0]  in_addr;
  logic [7:0]  in_data;
  logic [8:0]  in_pos;
  logic [5:0]  in_size;
  logic        in_be;
  logic        in_sgn;
  logic [31:0] in_sig;
  cmd_e        in_cmd;
  logic        accept;

  assign in_addr = s_axis_tdata_i[5:0];
  assign in_data = s_axis_tdata_i[13:6];
  assign in_pos  = s_axis_tdata_i[22:14];
  assign in_size = clamp_size(s_axis_tdata_i[28:23]);
  assign in_be   = s_axis_tdata_i[29];
  assign in_sgn  = s_axis_tdata_i[30];
  assign in_sig  = s_axis_tdata_i[62:31];
  assign in_cmd  = cmd_e'(s_axis_tuser_i);

  // lsb position of the signal
  logic [9:0] in_lsb;
  assign in_lsb = in_be ? (({1'b0, in_pos ^ 9'h7} + {4'b0, in_size} - 10'd1) ^ 10'h7)
                        : {1'b0, in_pos};

  state_e      state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  cmd_e        cmd_q;
  logic [5:0]  addr_q;
  logic [7:0]  data_q;
  logic [5:0]  size_q;
  logic        be_q;
  logic        sgn_q;
  logic [31:0] sig_q;
  logic [6:0]  base_q;
  logic [2:0]  shift_q;
  logic [2:0]  touched_q;
  logic [WinBits-1:0] word_q;
  logic        rd_pend_q, rd_pend_d;
  logic        rd_ok_q;
  logic [2:0]  rd_k_q;
  logic        out_valid_q;
  logic [47:0] out_data_q;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  logic is_sig;
  logic [2:0] n_bytes;
  assign is_sig  = (cmd_q == CMD_INSERT) || (cmd_q == CMD_EXTRACT);
  assign n_bytes = is_sig ? 3'(WinBytes) : 3'd1;

  // current buffer index: window byte step_q, or the byte address
  logic [IDX_W-1:0] win_idx;
  logic [CMP_W-1:0] cur_idx;
  logic             cur_ok;
  logic [ADDR_W-1:0] cur_addr;

  assign win_idx = be_q ? ({3'b000, base_q} - {7'b0, step_q})
                        : ({3'b000, base_q} + {7'b0, step_q});
  assign cur_idx = is_sig ? CMP_W'(win_idx) : CMP_W'(addr_q);
  assign cur_ok  = !(is_sig && win_idx[IDX_W-1]) && (cur_idx < CMP_W'(BUFFER_BYTES));
  assign cur_addr = cur_idx[ADDR_W-1:0];

  // insert merge and extract
  logic [31:0]        mask;
  logic [WinBits-1:0] ins_mask;
  logic [WinBits-1:0] merged;
  logic [WinBits-1:0] shifted;
  logic [31:0]        ext_val;
  logic [31:0]        smask;
  logic [31:0]        sig_out;

  assign mask     = 32'hFFFF_FFFF >> (SizeMax - size_q);
  assign ins_mask = WinBits'(mask) << shift_q;
  assign merged   = (word_q & ~ins_mask) | (WinBits'(sig_q & mask) << shift_q);
  assign shifted  = word_q >> shift_q;
  assign ext_val  = shifted[SigWidth-1:0] & mask;
  assign smask    = ~(mask >> 1);
  assign sig_out  = (sgn_q && ((ext_val & smask) != 32'd0)) ? (ext_val | smask) : ext_val;

  // buffer RAM
  logic [7:0]        mem_q [BUFFER_BYTES];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[cur_addr];
    end
  end

  logic out_load;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    clr_d     = clr_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = 8'd0;
    rd_pend_d = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(BUFFER_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          step_d  = 3'd0;
          state_d = (in_cmd == CMD_WR_BYTE) ? S_WRITE : S_READ;
        end
      end
      S_READ: begin
        if (step_q != n_bytes) begin
          mem_re    = cur_ok;
          rd_pend_d = 1'b1;
          step_d    = step_q + 3'd1;
        end else begin
          // last byte lands in word_q this cycle
          step_d  = 3'd0;
          state_d = (cmd_q == CMD_INSERT) ? S_WRITE : S_FIN;
        end
      end
      S_WRITE: begin
        mem_we    = cur_ok;
        mem_wdata = is_sig ? merged[8*step_q +: 8] : data_q;
        if (step_q == n_bytes - 3'd1) begin
          step_d  = 3'd0;
          state_d = S_FIN;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= 3'd0;
      clr_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      clr_q       <= clr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_load | (out_valid_q & ~m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_cmd;
      addr_q    <= in_addr;
      data_q    <= in_data;
      size_q    <= in_size;
      be_q      <= in_be;
      sgn_q     <= in_sgn;
      sig_q     <= in_sig;
      base_q    <= in_lsb[9:3];
      shift_q   <= in_lsb[2:0];
      touched_q <= ((in_cmd == CMD_INSERT) || (in_cmd == CMD_EXTRACT))
                   ? span_bytes(in_pos[2:0], in_size, in_be) : 3'd1;
    end
    rd_ok_q <= cur_ok;
    rd_k_q  <= step_q;
    if (rd_pend_q) begin
      word_q[8*rd_k_q +: 8] <= rd_ok_q ? mem_rdata_q : 8'd0;
    end
    if (out_load) begin
      out_data_q <= {5'd0, touched_q,
                     (cmd_q == CMD_EXTRACT) ? sig_out : 32'd0,
                     (cmd_q == CMD_RD_BYTE) ? word_q[7:0] : 8'd0};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_WRITE))
    else $error("buffer written outside clear or write-back");

  a_we_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CMP_W'(mem_waddr) < CMP_W'(BUFFER_BYTES)))
    else $error("buffer write address beyond buffer");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overwritten while held");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("new transfer taken while a command is in flight");
`endif

endmodule

`default_nettype wire
